// ===== design/srf_pkg.sv =====
// ---------------------------------------------------------------------------
// srf_pkg
// Shared types and constants of the singleton relation filter.
// ---------------------------------------------------------------------------
package srf_pkg;

    localparam logic OP_COUNT = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef struct packed {
        logic        op;
        logic [15:0] ideal_index;
        logic        relation_end;
    } in_item_t;

    typedef struct packed {
        logic        keep;
        logic [16:0] distinct_ideals;
        logic [31:0] kept_relations;
    } result_item_t;

    typedef struct packed {
        logic     considered;
        in_item_t item;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_FETCH,
        BK_EXEC
    } back_state_t;

endpackage

// ===== design/srf_front.sv =====
// ---------------------------------------------------------------------------
// srf_front
// Accepts items, holds the min_column register and marks each item as
// considered or ignored before it enters the queue.
// ---------------------------------------------------------------------------
module srf_front #(
    parameter int TABLE_DEPTH = 65536
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [15:0]       cfg_data,
    input  logic              item_valid,
    output logic              item_stall,
    input  srf_pkg::in_item_t item,
    input  logic              clearing,
    input  srf_pkg::q_status_t q_status,
    output logic              push,
    output srf_pkg::q_entry_t push_entry
);

    localparam logic [24:0] DEPTH_LIM = 25'(TABLE_DEPTH);

    logic [15:0] min_column_reg;
    logic [15:0] min_column_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        min_column_next = min_column_reg;
        if (cfg_valid && cfg_ready)
        begin
            min_column_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_column_reg <= 16'd0;
        end
        else
        begin
            min_column_reg <= min_column_next;
        end
    end

    assign item_stall = clearing || q_status.full;
    assign push       = item_valid && !item_stall;

    always_comb
    begin
        push_entry.item       = item;
        push_entry.considered = (item.ideal_index >= min_column_reg)
                             && ({9'd0, item.ideal_index} < DEPTH_LIM);
    end

endmodule

// ===== design/srf_queue.sv =====
// ---------------------------------------------------------------------------
// srf_queue
// Short queue of classified items between the front and the back.
// ---------------------------------------------------------------------------
module srf_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  srf_pkg::q_entry_t  push_entry,
    input  logic               pop,
    output srf_pkg::q_entry_t  head,
    output srf_pkg::q_status_t q_status
);

    localparam logic [srf_pkg::QPTR_W:0] FULL_COUNT = (srf_pkg::QPTR_W + 1)'(srf_pkg::QUEUE_DEPTH);

    srf_pkg::q_entry_t entries_reg [srf_pkg::QUEUE_DEPTH];

    logic [srf_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [srf_pkg::QPTR_W-1:0] wr_ptr_next;
    logic [srf_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [srf_pkg::QPTR_W-1:0] rd_ptr_next;
    logic [srf_pkg::QPTR_W:0]   count_reg;
    logic [srf_pkg::QPTR_W:0]   count_next;
    logic                       do_push;
    logic                       do_pop;

    assign q_status.full  = (count_reg == FULL_COUNT);
    assign q_status.empty = (count_reg == '0);
    assign do_push        = push && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign head           = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== design/srf_back.sv =====
// ---------------------------------------------------------------------------
// srf_back
// Clears the weight memory after reset, then runs one read-modify-write per
// queued item, keeps the relation counters and holds the result register.
// ---------------------------------------------------------------------------
module srf_back #(
    parameter int TABLE_DEPTH = 65536,
    parameter int WEIGHT_BITS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  srf_pkg::q_entry_t     head,
    input  srf_pkg::q_status_t    q_status,
    output logic                  pop,
    output logic                  clearing,
    output logic                  result_valid,
    input  logic                  result_stall,
    output srf_pkg::result_item_t result
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);

    logic [WEIGHT_BITS-1:0] mem [TABLE_DEPTH];

    srf_pkg::back_state_t state_reg;
    srf_pkg::back_state_t state_next;

    logic [ADDR_W-1:0]      clr_addr_reg;
    logic [ADDR_W-1:0]      clr_addr_next;
    srf_pkg::q_entry_t      cur_reg;
    logic [WEIGHT_BITS-1:0] rd_data_reg;
    logic [16:0]            distinct_reg;
    logic [16:0]            distinct_next;
    logic [31:0]            kept_reg;
    logic [31:0]            kept_next;
    logic                   seen_reg;
    logic                   seen_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    srf_pkg::result_item_t  out_reg;
    srf_pkg::result_item_t  out_next;

    logic                   rd_en;
    logic [ADDR_W-1:0]      rd_addr;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [WEIGHT_BITS-1:0] wr_data;
    logic                   fire;
    logic                   load_out;
    logic                   cnt_hit;
    logic                   chk_hit;
    logic                   seen_eff;
    logic                   keep_bit;
    logic [23:0]            head_ext;
    logic [23:0]            cur_ext;

    assign head_ext = {8'd0, head.item.ideal_index};
    assign cur_ext  = {8'd0, cur_reg.item.ideal_index};

    assign cnt_hit  = cur_reg.considered && (cur_reg.item.op == srf_pkg::OP_COUNT);
    assign chk_hit  = cur_reg.considered && (cur_reg.item.op == srf_pkg::OP_CHECK);
    assign seen_eff = seen_reg || (chk_hit && (rd_data_reg == WEIGHT_BITS'(1)));
    assign keep_bit = (cur_reg.item.op == srf_pkg::OP_CHECK) && !seen_eff;

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        case (state_reg)
            srf_pkg::BK_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = srf_pkg::BK_FETCH;
                end
            end
            srf_pkg::BK_FETCH:
            begin
                if (!q_status.empty)
                begin
                    state_next = srf_pkg::BK_EXEC;
                end
            end
            srf_pkg::BK_EXEC:
            begin
                if (fire)
                begin
                    state_next = srf_pkg::BK_FETCH;
                end
            end
            default:
            begin
                state_next = srf_pkg::BK_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        clearing = 1'b0;
        pop      = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = head_ext[ADDR_W-1:0];
        wr_en    = 1'b0;
        wr_addr  = cur_ext[ADDR_W-1:0];
        wr_data  = rd_data_reg + 1'b1;
        fire     = 1'b0;
        case (state_reg)
            srf_pkg::BK_CLEAR:
            begin
                clearing = 1'b1;
                wr_en    = 1'b1;
                wr_addr  = clr_addr_reg;
                wr_data  = '0;
            end
            srf_pkg::BK_FETCH:
            begin
                pop   = !q_status.empty;
                rd_en = !q_status.empty;
            end
            srf_pkg::BK_EXEC:
            begin
                fire  = !(cur_reg.item.relation_end && out_valid_reg && result_stall);
                wr_en = fire && cnt_hit && (rd_data_reg != '1);
            end
            default:
            begin
                clearing = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        distinct_next = distinct_reg;
        kept_next     = kept_reg;
        seen_next     = seen_reg;
        load_out      = 1'b0;
        if (fire)
        begin
            if (cnt_hit && (rd_data_reg == '0) && (distinct_reg != '1))
            begin
                distinct_next = distinct_reg + 1'b1;
            end
            if (cur_reg.item.relation_end)
            begin
                seen_next = 1'b0;
                load_out  = 1'b1;
                if (keep_bit && (kept_reg != '1))
                begin
                    kept_next = kept_reg + 1'b1;
                end
            end
            else
            begin
                seen_next = seen_eff;
            end
        end
    end

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;
        if (load_out)
        begin
            out_valid_next          = 1'b1;
            out_next.keep           = keep_bit;
            out_next.distinct_ideals = distinct_next;
            out_next.kept_relations = kept_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srf_pkg::BK_CLEAR;
            clr_addr_reg  <= '0;
            distinct_reg  <= '0;
            kept_reg      <= '0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            distinct_reg  <= distinct_next;
            kept_reg      <= kept_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (pop)
        begin
            cur_reg <= head;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ===== design/singleton_relation_filter_unit.sv =====
// ---------------------------------------------------------------------------
// singleton_relation_filter_unit
// Two-pass singleton filter: counts ideal weights, then keeps or drops each
// relation, with a classifying front, a short queue and a memory back end.
//
//   channel   direction  handshake            payload
//   item      in         item_valid/stall     srf_pkg::in_item_t
//   result    out        result_valid/stall   srf_pkg::result_item_t
//   cfg       in         cfg_valid/ready      cfg_data (min_column)
//
// In the back end each item is read from the weight memory in BK_FETCH,
// then BK_EXEC does the update write, waiting while a finished result stalls.
// After reset the weight memory is swept to zero, one entry per cycle,
// over all TABLE_DEPTH entries; item_stall stays high during the sweep.
// The front keeps taking items into a 4-entry queue while the back end
// waits on a stalled result.
// ---------------------------------------------------------------------------
module singleton_relation_filter_unit #(
    parameter int TABLE_DEPTH = 65536,
    parameter int WEIGHT_BITS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [15:0]           cfg_data,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  srf_pkg::in_item_t     item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output srf_pkg::result_item_t result
);

    logic               clearing;
    logic               push;
    logic               pop;
    srf_pkg::q_entry_t  push_entry;
    srf_pkg::q_entry_t  head;
    srf_pkg::q_status_t q_status;

    srf_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .clearing   (clearing),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    srf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_status   (q_status)
    );

    srf_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_status     (q_status),
        .pop          (pop),
        .clearing     (clearing),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && clearing))
        else $error("item accepted during memory clear");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_status.full))
        else $error("push into full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && q_status.empty))
        else $error("pop from empty queue");

    a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue full and empty at once");

endmodule
